[rtl/tile_grid_collision_and_spawn_assert.svh]
// Assertion macros for the tile grid collision and spawn block.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef TILE_GRID_COLLISION_AND_SPAWN_ASSERT_SVH
`define TILE_GRID_COLLISION_AND_SPAWN_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TGCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tgcs_pkg.sv]
// Shared types and constants of the tile grid collision and spawn block.
// No dependencies; imported by every module of the block.
`default_nettype none

package tgcs_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int CFG_W   = 7;   // width of every configuration register
    localparam int CRD_W   = 9;   // holds a map size up to 256
    localparam int IDX_W   = 8;   // holds a grid coordinate up to 255
    localparam int OUT_W   = 14;  // spawn coordinate width
    localparam int PROD_W  = 16;  // (2*col+1)*tile product width

    localparam int DIV_NUM_W      = 13;  // nonnegative dividend width
    localparam int DIV_RADIX_BITS = 4;   // quotient bits resolved per cycle
    localparam int DIV_STEPS      = (DIV_NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_PAD_W      = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_SPAWN = 2'd2;

    localparam logic [1:0] CFG_TILE_W = 2'd0;
    localparam logic [1:0] CFG_TILE_H = 2'd1;
    localparam logic [1:0] CFG_MAP_W  = 2'd2;
    localparam logic [1:0] CFG_MAP_H  = 2'd3;

    localparam logic [CFG_W-1:0] TILE_RESET = 7'd16;
    localparam logic [CFG_W-1:0] MAP_RESET  = 7'd64;
    localparam logic [CFG_W-1:0] TILE_MAX   = 7'd64;

    localparam logic [OUT_W-1:0] FALLBACK_HALF = 14'd200;

    // bit positions of a stored cell
    localparam int WALL_POS  = 0;
    localparam int FLOOR_POS = 1;

    typedef struct packed {
        logic             spawn;  // 1: look for floor without wall, 0: look for wall
        logic [IDX_W-1:0] c0;
        logic [IDX_W-1:0] c1;
        logic [IDX_W-1:0] r0;
        logic [IDX_W-1:0] r1;
    } t_scan_req;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } t_scan_res;

    function automatic logic [CFG_W-1:0] clamp_tile(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] v;
        v = raw;
        if (v == '0) begin
            v = CFG_W'(1);
        end else if (v > TILE_MAX) begin
            v = TILE_MAX;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/tgcs_div.sv]
// Iterative restoring divider: nonnegative dividend by a tile size.
// Resolves DIV_RADIX_BITS quotient bits per cycle; depends on tgcs_pkg.
`default_nettype none

module tgcs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tgcs_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [tgcs_pkg::CFG_W-1:0]    i_den,
    output logic                               o_done,
    output logic [tgcs_pkg::DIV_NUM_W-1:0]     o_quo
);
    import tgcs_pkg::*;

    logic [DIV_PAD_W-1:0] r_acc, n_acc;   // dividend bits out at top, quotient in at bottom
    logic [CFG_W-2:0]     r_rem, n_rem;
    logic [CFG_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_comb begin
        logic [CFG_W-1:0] rs;
        logic             ge;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            rs    = {n_rem, n_acc[DIV_PAD_W-1]};
            ge    = (rs >= r_den);
            n_rem = ge ? (CFG_W-1)'(rs - r_den) : rs[CFG_W-2:0];
            n_acc = {n_acc[DIV_PAD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= DIV_PAD_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_acc[DIV_NUM_W-1:0];

endmodule

`default_nettype wire

[rtl/tgcs_cellmem.sv]
// Cell memory: wall and floor bit per grid cell, one write and one read port.
// Sweeps itself to zero after reset; depends on tgcs_pkg.
`default_nettype none

module tgcs_cellmem #(
    parameter int MAX_COLS = tgcs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tgcs_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_we,
    input  wire logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]   i_waddr,
    input  wire logic [1:0]                                      i_wdata,
    input  wire logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]   i_raddr,
    output logic [1:0]                                           o_rdata,
    output logic                                                 o_clearing
);
    import tgcs_pkg::*;

    localparam int AW    = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
    localparam int DEPTH = 1 << AW;

    logic [1:0]    r_mem [DEPTH];
    logic [1:0]    r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_on   <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_on) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_on) begin
            r_mem[r_clr_addr] <= 2'b00;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr_on;

endmodule

`default_nettype wire

[rtl/tgcs_scan.sv]
// Span scanner: walks a rectangle of cells in row-major order through the
// cell memory's read port and stops at the first match; depends on tgcs_pkg.
`default_nettype none

module tgcs_scan #(
    parameter int MAX_COLS = tgcs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tgcs_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_start,
    input  wire tgcs_pkg::t_scan_req                             i_req,
    output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]         o_raddr,
    input  wire logic [1:0]                                      i_rdata,
    output tgcs_pkg::t_scan_res                                  o_res
);
    import tgcs_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic             r_spawn;
    logic [COL_W-1:0] r_c0, r_c1, r_c, r_pc;
    logic [ROW_W-1:0] r_r1, r_r, r_pr;
    logic             r_run;
    logic             r_pend;   // a read is in flight, its data is on i_rdata
    logic             r_plast;  // the read in flight is the last cell of the span
    logic             r_done;
    logic             r_found;
    logic [COL_W-1:0] r_fc;
    logic [ROW_W-1:0] r_fr;

    logic last;
    logic match;
    logic hit_now;

    always_comb begin
        last    = (r_c == r_c1) && (r_r == r_r1);
        match   = r_spawn ? (!i_rdata[WALL_POS] && i_rdata[FLOOR_POS]) : i_rdata[WALL_POS];
        hit_now = r_pend && match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_pend <= 1'b0;
            end else begin
                if (r_pend && (hit_now || r_plast)) begin
                    r_done <= 1'b1;
                end
                if (hit_now) begin
                    // drop the read still in flight
                    r_run  <= 1'b0;
                    r_pend <= 1'b0;
                end else if (r_run) begin
                    r_pend <= 1'b1;
                    if (last) begin
                        r_run <= 1'b0;
                    end
                end else begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_spawn <= i_req.spawn;
            r_c0    <= i_req.c0[COL_W-1:0];
            r_c1    <= i_req.c1[COL_W-1:0];
            r_r1    <= i_req.r1[ROW_W-1:0];
            r_c     <= i_req.c0[COL_W-1:0];
            r_r     <= i_req.r0[ROW_W-1:0];
        end else begin
            if (r_pend && (hit_now || r_plast)) begin
                r_found <= hit_now;
                r_fc    <= r_pc;
                r_fr    <= r_pr;
            end
            if (r_run && !hit_now) begin
                r_pc    <= r_c;
                r_pr    <= r_r;
                r_plast <= last;
                // advance along the row, wrap to the next row
                if (r_c == r_c1) begin
                    r_c <= r_c0;
                    r_r <= r_r + ROW_W'(1);
                end else begin
                    r_c <= r_c + COL_W'(1);
                end
            end
        end
    end

    assign o_raddr     = {r_r, r_c};
    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.col   = IDX_W'(r_fc);
    assign o_res.row   = IDX_W'(r_fr);

endmodule

`default_nettype wire

[rtl/tile_grid_collision_and_spawn.sv]
// Tile grid collision and spawn search. One item in, one result out, one item
// at a time. A cell write, or an item of the unused kind, goes straight to the
// done state. A collision query divides the rectangle edges by the tile sizes
// to turn them into a cell span. An out-of-map or empty span skips the walk
// and ends the item. Any other span is walked at one cell per cycle through
// the single read port of the cell memory, stopping at the first wall. A spawn
// search walks up to (map_width-2)*(map_height-2) inner cells at one per cycle;
// a map without inner cells skips the walk. A finished item is held in its done
// state while the previous result waits to be taken. After reset the cell
// memory sweeps all 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells to zero (4096 at
// the default size) and takes no item until it is done; configuration writes
// are taken at any time. The result sits in an output register, so the next
// item is accepted while a result waits to be taken.
// Depends on tgcs_pkg, tgcs_div, tgcs_cellmem, tgcs_scan and the assertion header.
`default_nettype none

module tile_grid_collision_and_spawn #(
    parameter int MAX_COLS = tgcs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tgcs_pkg::DEF_MAX_ROWS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [tgcs_pkg::CFG_W-1:0]   i_cfg_wdata,
    // item channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [5:0]                   i_cell_col,
    input  wire logic [5:0]                   i_cell_row,
    input  wire logic                         i_wall_bit,
    input  wire logic                         i_floor_bit,
    input  wire logic signed [12:0]           i_rect_left,
    input  wire logic signed [12:0]           i_rect_top,
    input  wire logic [11:0]                  i_rect_w,
    input  wire logic [11:0]                  i_rect_h,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_hit,
    output logic                              o_spawn_found,
    output logic [tgcs_pkg::OUT_W-1:0]        o_spawn_x_half,
    output logic [tgcs_pkg::OUT_W-1:0]        o_spawn_y_half
);
    import tgcs_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int AW    = COL_W + ROW_W;
    localparam int SUM_W = DIV_NUM_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic             hit;
        logic             found;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } t_result;

    t_state  r_state, n_state;
    t_result r_res, n_res;
    logic    r_ovalid;
    t_result r_out;
    logic    r_spawn;

    logic [CFG_W-1:0] r_tile_w, r_tile_h, r_map_w, r_map_h;
    logic [CFG_W-1:0] tw, th;
    logic [CRD_W-1:0] mw, mh;

    logic accept;
    logic out_free;
    logic mem_clearing;

    // divider lanes: left, right, top, bottom
    logic [SUM_W-1:0]     xs, xe, ys, ye;
    logic [DIV_NUM_W-1:0] div_num [4];
    logic [CFG_W-1:0]     div_den [4];
    logic [DIV_NUM_W-1:0] div_quo [4];
    logic [3:0]           div_done;
    logic                 div_start;
    logic [3:0]           r_neg;

    logic [CRD_W-1:0] wcol, wrow;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [1:0]       mem_rdata;

    logic      scan_start;
    t_scan_req scan_req;
    t_scan_res scan_res;

    logic                 out_of_map, empty_span;
    logic [DIV_NUM_W-1:0] mw_ext, mh_ext;
    logic [PROD_W-1:0]    prod_x, prod_y;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= TILE_RESET;
            r_tile_h <= TILE_RESET;
            r_map_w  <= MAP_RESET;
            r_map_h  <= MAP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TILE_W: r_tile_w <= i_cfg_wdata;
                CFG_TILE_H: r_tile_h <= i_cfg_wdata;
                CFG_MAP_W:  r_map_w  <= i_cfg_wdata;
                CFG_MAP_H:  r_map_h  <= i_cfg_wdata;
            endcase
        end
    end

    always_comb begin
        tw = clamp_tile(r_tile_w);
        th = clamp_tile(r_tile_h);
        mw = CRD_W'(r_map_w);
        mh = CRD_W'(r_map_h);
        if (mw == '0) begin
            mw = CRD_W'(1);
        end else if (mw > CRD_W'(MAX_COLS)) begin
            mw = CRD_W'(MAX_COLS);
        end
        if (mh == '0) begin
            mh = CRD_W'(1);
        end else if (mh > CRD_W'(MAX_ROWS)) begin
            mh = CRD_W'(MAX_ROWS);
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && !mem_clearing;
    assign accept   = i_valid && o_ready;

    // cell write goes to memory in the accept cycle
    always_comb begin
        wcol      = CRD_W'(i_cell_col);
        wrow      = CRD_W'(i_cell_row);
        mem_we    = accept && (i_kind == KIND_WRITE) &&
                    (wcol < CRD_W'(MAX_COLS)) && (wrow < CRD_W'(MAX_ROWS));
        mem_waddr = {wrow[ROW_W-1:0], wcol[COL_W-1:0]};
    end

    // rectangle edges: first and last pixel, sign-extended
    always_comb begin
        xs = SUM_W'(signed'(i_rect_left));
        ys = SUM_W'(signed'(i_rect_top));
        xe = xs + SUM_W'(i_rect_w) - SUM_W'(1);
        ye = ys + SUM_W'(i_rect_h) - SUM_W'(1);
        div_num[0] = xs[DIV_NUM_W-1:0];
        div_num[1] = xe[DIV_NUM_W-1:0];
        div_num[2] = ys[DIV_NUM_W-1:0];
        div_num[3] = ye[DIV_NUM_W-1:0];
        div_den[0] = tw;
        div_den[1] = tw;
        div_den[2] = th;
        div_den[3] = th;
        div_start  = accept && (i_kind == KIND_RECT);
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        tgcs_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (div_num[g]),
            .i_den   (div_den[g]),
            .o_done  (div_done[g]),
            .o_quo   (div_quo[g])
        );
    end

    // a negative edge takes its quotient as negative, whatever the magnitude
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg <= {ye[SUM_W-1], ys[SUM_W-1], xe[SUM_W-1], xs[SUM_W-1]};
        end
    end

    always_comb begin
        mw_ext     = DIV_NUM_W'(mw);
        mh_ext     = DIV_NUM_W'(mh);
        out_of_map = r_neg[0] || r_neg[2] ||
                     (!r_neg[1] && (div_quo[1] >= mw_ext)) ||
                     (!r_neg[3] && (div_quo[3] >= mh_ext));
        empty_span = r_neg[1] || r_neg[3] ||
                     (div_quo[1] < div_quo[0]) || (div_quo[3] < div_quo[2]);
    end

    always_comb begin
        prod_x = PROD_W'({scan_res.col, 1'b1}) * PROD_W'(tw);
        prod_y = PROD_W'({scan_res.row, 1'b1}) * PROD_W'(th);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        scan_start = 1'b0;
        scan_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    if (i_kind == KIND_RECT) begin
                        n_state = S_DIV;
                    end else if (i_kind == KIND_SPAWN) begin
                        n_res.x = FALLBACK_HALF;
                        n_res.y = FALLBACK_HALF;
                        if ((mw >= CRD_W'(3)) && (mh >= CRD_W'(3))) begin
                            scan_start     = 1'b1;
                            scan_req.spawn = 1'b1;
                            scan_req.c0    = IDX_W'(1);
                            scan_req.r0    = IDX_W'(1);
                            scan_req.c1    = IDX_W'(mw - CRD_W'(2));
                            scan_req.r1    = IDX_W'(mh - CRD_W'(2));
                            n_state        = S_SCAN;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done[0]) begin
                    if (out_of_map) begin
                        n_res.hit = 1'b1;
                        n_state   = S_DONE;
                    end else if (empty_span) begin
                        n_state = S_DONE;
                    end else begin
                        scan_start     = 1'b1;
                        scan_req.spawn = 1'b0;
                        scan_req.c0    = IDX_W'(div_quo[0]);
                        scan_req.c1    = IDX_W'(div_quo[1]);
                        scan_req.r0    = IDX_W'(div_quo[2]);
                        scan_req.r1    = IDX_W'(div_quo[3]);
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = S_DONE;
                    if (!r_spawn) begin
                        n_res.hit = scan_res.found;
                    end else if (scan_res.found) begin
                        n_res.found = 1'b1;
                        n_res.x     = prod_x[OUT_W-1:0];
                        n_res.y     = prod_y[OUT_W-1:0];
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (scan_start) begin
            r_spawn <= scan_req.spawn;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    tgcs_cellmem #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (mem_we),
        .i_waddr    (mem_waddr),
        .i_wdata    ({i_floor_bit, i_wall_bit}),
        .i_raddr    (mem_raddr),
        .o_rdata    (mem_rdata),
        .o_clearing (mem_clearing)
    );

    tgcs_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_req   (scan_req),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata),
        .o_res   (scan_res)
    );

    assign o_valid        = r_ovalid;
    assign o_hit          = r_out.hit;
    assign o_spawn_found  = r_out.found;
    assign o_spawn_x_half = r_out.x;
    assign o_spawn_y_half = r_out.y;

`include "tile_grid_collision_and_spawn_assert.svh"

    // one item at a time: ready drops right after a beat is taken
    `TGCS_ASSERT_NEXT(a_one_item, accept, !o_ready, "item accepted while another is in work")
    // span results only arrive while the sequencer waits for them
    `TGCS_ASSERT_NOW(a_scan_done_state, scan_res.done, r_state == S_SCAN, "stray scan result")
    // divider results only arrive while the sequencer waits for them
    `TGCS_ASSERT_NOW(a_div_done_state, div_done[0], r_state == S_DIV, "stray divider result")
    // a finished result never overwrites one that is still waiting
    `TGCS_ASSERT_NEXT(a_hold_result, (r_state == S_DONE) && r_ovalid && !i_ready,
                      r_state == S_DONE, "result register overrun")

endmodule

`default_nettype wire
